FILE: hw/rtl/atm_pkg.sv
// ----------------------------------------------------------------------------
// atm_pkg
// Widths, stage counts and pipeline types shared by the triangle mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package atm_pkg;

    localparam int CW   = 16;               // coordinate width, Q12.4
    localparam int CF   = 4;                // coordinate fraction bits
    localparam int FRAC = 16;               // coefficient fraction bits
    localparam int OW   = 48;               // coefficient width
    localparam int NF   = 12;               // coordinates per input word
    localparam int NC   = 6;                // coefficients per output word

    localparam int DFW  = CW + 1;           // vertex difference
    localparam int PW   = 2 * DFW;          // difference product
    localparam int KW   = PW + 1;           // determinant and cofactors
    localparam int MW   = CW + KW;          // vertex times cofactor
    localparam int NCW  = MW + 2;           // translation numerator
    localparam int SHC  = FRAC - CF;        // shift of translation numerator
    localparam int NMW  = (KW + FRAC > NCW + SHC) ? KW + FRAC : NCW + SHC;
    localparam int RW   = KW - 1;           // divisor and remainder
    localparam int HW   = NMW - OW;         // numerator bits above the quotient

    localparam int NSU  = 6;                // setup stages
    localparam int NS   = NSU + OW + 1;     // all stages, last one is the output

    localparam int IDW  = NF * CW;
    localparam int ODW  = NC * OW;

    // field positions in the input word
    localparam int SX1 = 0;
    localparam int SX2 = 1;
    localparam int SX3 = 2;
    localparam int SY1 = 3;
    localparam int SY2 = 4;
    localparam int SY3 = 5;
    localparam int DX1 = 6;
    localparam int DX2 = 7;
    localparam int DX3 = 8;
    localparam int DY1 = 9;
    localparam int DY2 = 10;
    localparam int DY3 = 11;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [OW-1:0] num;     // remaining dividend bits, MSB first
        logic [OW-1:0] quo;
        logic [RW-1:0] d;
        logic          neg;
        logic          ovf;
        logic          zero;
    } t_div_st;

endpackage

`default_nettype wire

FILE: hw/rtl/atm_ctrl.sv
// ----------------------------------------------------------------------------
// atm_ctrl
// Valid bits of every stage and the per-stage load enables.
// ----------------------------------------------------------------------------
`default_nettype none

module atm_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [atm_pkg::NS-1:0] o_en
);
    import atm_pkg::*;

    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] adv;

    // a stage loads when it is empty or its word moves on
    always_comb begin
        adv[NS-1] = !r_v[NS-1] || i_m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
        n_v[0] = adv[0] ? i_s_tvalid : r_v[0];
        for (int k = 1; k < NS; k++) begin
            n_v[k] = adv[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_en       = adv;
    assign o_s_tready = adv[0];
    assign o_m_tvalid = r_v[NS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/atm_setup.sv
// ----------------------------------------------------------------------------
// atm_setup
// Differences, determinant, cofactors and translation numerators, then
// dividend magnitudes and signs ready for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module atm_setup (
    input  logic                     i_clk,
    input  logic [atm_pkg::NSU-1:0]  i_en,
    input  logic [atm_pkg::IDW-1:0]  i_tdata,
    output atm_pkg::t_div_st         o_st [atm_pkg::NC]
);
    import atm_pkg::*;

    function automatic t_div_st mk_div(input logic [NMW:0] n, input logic [RW-1:0] d,
                                       input logic dneg, input logic dz);
        logic [NMW:0]  mag;
        logic [RW-1:0] hi;
        t_div_st       st;
        mag     = n[NMW] ? (~n + {{NMW{1'b0}}, 1'b1}) : n;
        hi      = {{(RW-HW){1'b0}}, mag[NMW-1:OW]};
        st.num  = mag[OW-1:0];
        st.rem  = hi;
        st.ovf  = hi >= d;
        st.quo  = '0;
        st.d    = d;
        st.neg  = n[NMW] ^ dneg;
        st.zero = dz;
        return st;
    endfunction

    logic signed [CW-1:0]  c [NF];
    logic signed [DFW-1:0] r1_d [8];    // dx2 dx3 dy2 dy3 dz2 dz3 dw2 dw3
    logic signed [CW-1:0]  r1_b [4];    // x1 y1 z1 w1
    logic signed [PW-1:0]  r2_p [10];
    logic signed [CW-1:0]  r2_b [4];
    logic signed [KW-1:0]  r3_k [5];    // det na nb nd ne
    logic signed [CW-1:0]  r3_b [4];
    logic signed [MW-1:0]  r4_m [6];
    logic signed [KW-1:0]  r4_k [5];
    logic signed [NCW-1:0] r5_nc;
    logic signed [NCW-1:0] r5_nf;
    logic signed [KW-1:0]  r5_k [5];
    logic signed [NMW:0]   num [NC];
    logic [RW-1:0]         dmag;
    logic [KW-1:0]         dneg_w;
    t_div_st               r6_st [NC];
    t_div_st               o_st_n [NC];

    always_comb begin
        for (int k = 0; k < NF; k++) begin
            c[k] = i_tdata[k*CW +: CW];
        end
    end

    function automatic logic signed [DFW-1:0] dif(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    function automatic logic signed [KW-1:0] sub_p(input logic signed [PW-1:0] a,
                                                   input logic signed [PW-1:0] b);
        return $signed({a[PW-1], a}) - $signed({b[PW-1], b});
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_d[0] <= dif(c[SX2], c[SX1]);
            r1_d[1] <= dif(c[SX3], c[SX1]);
            r1_d[2] <= dif(c[SY2], c[SY1]);
            r1_d[3] <= dif(c[SY3], c[SY1]);
            r1_d[4] <= dif(c[DX2], c[DX1]);
            r1_d[5] <= dif(c[DX3], c[DX1]);
            r1_d[6] <= dif(c[DY2], c[DY1]);
            r1_d[7] <= dif(c[DY3], c[DY1]);
            r1_b[0] <= c[SX1];
            r1_b[1] <= c[SY1];
            r1_b[2] <= c[DX1];
            r1_b[3] <= c[DY1];
        end
        if (i_en[1]) begin
            r2_p[0] <= r1_d[0] * r1_d[3];
            r2_p[1] <= r1_d[1] * r1_d[2];
            r2_p[2] <= r1_d[4] * r1_d[3];
            r2_p[3] <= r1_d[5] * r1_d[2];
            r2_p[4] <= r1_d[0] * r1_d[5];
            r2_p[5] <= r1_d[1] * r1_d[4];
            r2_p[6] <= r1_d[6] * r1_d[3];
            r2_p[7] <= r1_d[7] * r1_d[2];
            r2_p[8] <= r1_d[0] * r1_d[7];
            r2_p[9] <= r1_d[1] * r1_d[6];
            r2_b    <= r1_b;
        end
        if (i_en[2]) begin
            for (int k = 0; k < 5; k++) begin
                r3_k[k] <= sub_p(r2_p[2*k], r2_p[2*k+1]);
            end
            r3_b <= r2_b;
        end
        if (i_en[3]) begin
            r4_m[0] <= r3_b[2] * r3_k[0];
            r4_m[1] <= r3_b[0] * r3_k[1];
            r4_m[2] <= r3_b[1] * r3_k[2];
            r4_m[3] <= r3_b[3] * r3_k[0];
            r4_m[4] <= r3_b[0] * r3_k[3];
            r4_m[5] <= r3_b[1] * r3_k[4];
            r4_k    <= r3_k;
        end
        if (i_en[4]) begin
            r5_nc <= $signed({{2{r4_m[0][MW-1]}}, r4_m[0]})
                   - $signed({{2{r4_m[1][MW-1]}}, r4_m[1]})
                   - $signed({{2{r4_m[2][MW-1]}}, r4_m[2]});
            r5_nf <= $signed({{2{r4_m[3][MW-1]}}, r4_m[3]})
                   - $signed({{2{r4_m[4][MW-1]}}, r4_m[4]})
                   - $signed({{2{r4_m[5][MW-1]}}, r4_m[5]});
            r5_k  <= r4_k;
        end
        if (i_en[5]) begin
            r6_st <= o_st_n;
        end
    end

    always_comb begin
        num[0] = {{(NMW+1-KW-FRAC){r5_k[1][KW-1]}}, r5_k[1], {FRAC{1'b0}}};
        num[1] = {{(NMW+1-KW-FRAC){r5_k[2][KW-1]}}, r5_k[2], {FRAC{1'b0}}};
        num[2] = {{(NMW+1-NCW-SHC){r5_nc[NCW-1]}}, r5_nc, {SHC{1'b0}}};
        num[3] = {{(NMW+1-KW-FRAC){r5_k[3][KW-1]}}, r5_k[3], {FRAC{1'b0}}};
        num[4] = {{(NMW+1-KW-FRAC){r5_k[4][KW-1]}}, r5_k[4], {FRAC{1'b0}}};
        num[5] = {{(NMW+1-NCW-SHC){r5_nf[NCW-1]}}, r5_nf, {SHC{1'b0}}};
        dneg_w = r5_k[0][KW-1] ? (~r5_k[0] + {{(KW-1){1'b0}}, 1'b1}) : r5_k[0];
        dmag   = dneg_w[RW-1:0];
        for (int k = 0; k < NC; k++) begin
            o_st_n[k] = mk_div(num[k], dmag, r5_k[0][KW-1], r5_k[0] == '0);
        end
    end

    assign o_st = r6_st;

endmodule

`default_nettype wire

FILE: hw/rtl/atm_div.sv
// ----------------------------------------------------------------------------
// atm_div
// Restoring divider, one quotient bit per stage, followed by saturation,
// sign and the degenerate zeroing in a final output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module atm_div (
    input  logic                  i_clk,
    input  logic [atm_pkg::OW:0]  i_en,
    input  atm_pkg::t_div_st      i_st,
    output logic [atm_pkg::OW-1:0] o_coef,
    output logic                  o_zero
);
    import atm_pkg::*;

    localparam logic [OW-1:0] POS_LIM = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] NEG_LIM = {1'b1, {(OW-1){1'b0}}};

    t_div_st r_st [OW];

    for (genvar j = 0; j < OW; j++) begin : g_bit
        t_div_st     s_in;
        t_div_st     n_st;
        logic [RW:0] t;
        logic [RW:0] diff;

        if (j == 0) begin : g_first
            assign s_in = i_st;
        end else begin : g_next
            assign s_in = r_st[j-1];
        end

        always_comb begin
            n_st     = s_in;
            t        = {s_in.rem, s_in.num[OW-1]};
            diff     = t - {1'b0, s_in.d};
            n_st.num = {s_in.num[OW-2:0], 1'b0};
            if (t >= {1'b0, s_in.d}) begin
                n_st.rem = diff[RW-1:0];
                n_st.quo = {s_in.quo[OW-2:0], 1'b1};
            end else begin
                n_st.rem = t[RW-1:0];
                n_st.quo = {s_in.quo[OW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_st[j] <= n_st;
            end
        end
    end

    logic [OW-1:0] lim;
    logic [OW-1:0] mag;
    logic [OW-1:0] n_coef;
    logic [OW-1:0] r_coef;
    logic          r_zero;

    always_comb begin
        lim = r_st[OW-1].neg ? NEG_LIM : POS_LIM;
        mag = (r_st[OW-1].ovf || r_st[OW-1].quo > lim) ? lim : r_st[OW-1].quo;
        if (r_st[OW-1].zero) begin
            n_coef = '0;
        end else if (r_st[OW-1].neg) begin
            n_coef = ~mag + {{(OW-1){1'b0}}, 1'b1};
        end else begin
            n_coef = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[OW]) begin
            r_coef <= n_coef;
            r_zero <= r_st[OW-1].zero;
        end
    end

    assign o_coef = r_coef;
    assign o_zero = r_zero;

endmodule

`default_nettype wire

FILE: hw/rtl/affine_triangle_mapping_top.sv
// ----------------------------------------------------------------------------
// affine_triangle_mapping_top
// Affine coefficients from a source and a destination triangle.
//
//   channel   dir   tdata                               tuser
//   s_axis    in    12 x 16b coords, src x1..y3, dst     -
//   m_axis    out   6 x 48b xx xy ox yx yy oy            degenerate
//
// One word per cycle sustained while m_axis is ready; 6 setup stages, one
// divider stage per quotient bit, one output stage.
// The 48 divider stages set the latency; every stage holds its word under
// stall and empty stages still load, so bubbles close up.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_triangle_mapping_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // src_x1 src_x2 src_x3 src_y1 src_y2 src_y3 dst_x1 dst_x2 dst_x3 dst_y1 dst_y2 dst_y3
    input  logic [atm_pkg::IDW-1:0]  i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // coef_xx coef_xy offset_x coef_yx coef_yy offset_y
    output logic [atm_pkg::ODW-1:0]  o_m_tdata,
    // degenerate
    output logic [0:0]               o_m_tuser
);
    import atm_pkg::*;

    logic [NS-1:0] en;
    t_div_st       st [NC];
    logic [NC-1:0] zero;

    atm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_en       (en)
    );

    atm_setup u_setup (
        .i_clk   (i_clk),
        .i_en    (en[NSU-1:0]),
        .i_tdata (i_s_tdata),
        .o_st    (st)
    );

    for (genvar k = 0; k < NC; k++) begin : g_div
        atm_div u_div (
            .i_clk  (i_clk),
            .i_en   (en[NS-1:NSU]),
            .i_st   (st[k]),
            .o_coef (o_m_tdata[k*OW +: OW]),
            .o_zero (zero[k])
        );
    end

    // all dividers see the same determinant
    assign o_m_tuser[0] = &zero;

endmodule

`default_nettype wire

FILE: hw/rtl/atm_chk.sv
// ----------------------------------------------------------------------------
// atm_chk
// Port-level checks of the triangle mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module atm_chk (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic                     o_s_tready,
    input  logic [atm_pkg::IDW-1:0]  i_s_tdata,
    input  logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [atm_pkg::ODW-1:0]  o_m_tdata,
    input  logic [0:0]               o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output word changed under stall");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("degenerate word with nonzero coefficients");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with nothing at the output");

endmodule

bind affine_triangle_mapping_top atm_chk u_atm_chk (.*);

`default_nettype wire
